[sv/aes_pkg.sv]
// Package with AES-128 constants, types and byte-level functions.
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumBytes  = 16;

  typedef logic [127:0] block_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    RegKeyHigh = 1'b0,
    RegKeyLow  = 1'b1
  } reg_idx_e;

  // Forward S-box.
  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5, 8'h30, 8'h01, 8'h67, 8'h2b,
    8'hfe, 8'hd7, 8'hab, 8'h76, 8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0, 8'hb7, 8'hfd, 8'h93, 8'h26,
    8'h36, 8'h3f, 8'hf7, 8'hcc, 8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a, 8'h07, 8'h12, 8'h80, 8'he2,
    8'heb, 8'h27, 8'hb2, 8'h75, 8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84, 8'h53, 8'hd1, 8'h00, 8'hed,
    8'h20, 8'hfc, 8'hb1, 8'h5b, 8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85, 8'h45, 8'hf9, 8'h02, 8'h7f,
    8'h50, 8'h3c, 8'h9f, 8'ha8, 8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2, 8'hcd, 8'h0c, 8'h13, 8'hec,
    8'h5f, 8'h97, 8'h44, 8'h17, 8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88, 8'h46, 8'hee, 8'hb8, 8'h14,
    8'hde, 8'h5e, 8'h0b, 8'hdb, 8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79, 8'he7, 8'hc8, 8'h37, 8'h6d,
    8'h8d, 8'hd5, 8'h4e, 8'ha9, 8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6, 8'he8, 8'hdd, 8'h74, 8'h1f,
    8'h4b, 8'hbd, 8'h8b, 8'h8a, 8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e, 8'he1, 8'hf8, 8'h98, 8'h11,
    8'h69, 8'hd9, 8'h8e, 8'h94, 8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68, 8'h41, 8'h99, 8'h2d, 8'h0f,
    8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the block, byte 0 at the top.
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
    get_byte = b[127 - 8 * i -: 8];
  endfunction

  // Next round key from the current one.
  function automatic block_t next_key(input block_t rk, input logic [7:0] rcon);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t  = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    w0 = rk[127:96] ^ t;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

  // SubBytes and ShiftRows, optional MixColumns, then AddRoundKey.
  function automatic block_t round_fn(input block_t s, input block_t rk, input logic mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    block_t     o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4 * c] = SBOX[get_byte(s, r + 4 * ((c + r) % 4))];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4 * c];
      a1 = t[4 * c + 1];
      a2 = t[4 * c + 2];
      a3 = t[4 * c + 3];
      if (mix) begin
        o[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        o[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        o[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        o[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end else begin
        o[127 - 32 * c -: 32] = {a0, a1, a2, a3};
      end
    end
    round_fn = o ^ rk;
  endfunction

endpackage

[sv/aes_stream_if.sv]
// Valid/ready stream interface carrying one 128-bit block as two halves.
interface aes_stream_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;

  modport source (output valid, output data_high, output data_low, input ready);
  modport sink (input valid, input data_high, input data_low, output ready);
endinterface

[sv/aes128_block_encrypt_top.sv]
// AES-128 encryption top level: key registers, chain of ten round cells, output stage.
//
//  channel   direction  transfer      payload
//  in_if     sink       valid/ready   data_high, data_low (plaintext)
//  out_if    source     valid/ready   data_high, data_low (ciphertext)
//  APB       slave      psel/penable  key_high at 0x0, key_low at 0x8
//
// One block enters per cycle while the chain is not stalled. Each block is
// registered first in the initial key addition stage and then in each of the
// ten round cells in turn; the last cell's register presents the result.
// Reset clears all valid flags and the key registers. The chain advances
// whenever the output stage is empty or being taken; a stall downstream
// freezes the whole chain and drops ready.
module aes128_block_encrypt_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  aes_stream_if.sink         in_if,
  aes_stream_if.source       out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int unsigned Cells = aes_pkg::NumRounds;
  localparam logic [7:0] RCON [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                      8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  logic [63:0]     key_high_q, key_low_q;
  logic            en;
  logic            valid0_q;
  aes_pkg::block_t state0_q, key0_q;
  logic            cell_valid [Cells];
  aes_pkg::block_t cell_state [Cells];
  aes_pkg::block_t cell_key   [Cells];

  // Register file writes.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      case (aes_pkg::reg_idx_e'(paddr[3]))
        aes_pkg::RegKeyHigh: key_high_q <= pwdata;
        aes_pkg::RegKeyLow:  key_low_q  <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      case (aes_pkg::reg_idx_e'(paddr[3]))
        aes_pkg::RegKeyHigh: prdata = key_high_q;
        aes_pkg::RegKeyLow:  prdata = key_low_q;
        default: prdata = '0;
      endcase
    end
  end

  // The chain moves when the last cell's result can be taken or is empty.
  assign en          = !cell_valid[Cells - 1] || out_if.ready;
  assign in_if.ready = en;

  // Initial AddRoundKey stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else if (en) begin
      valid0_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      state0_q <= {in_if.data_high, in_if.data_low} ^ {key_high_q, key_low_q};
      key0_q   <= {key_high_q, key_low_q};
    end
  end

  // Chain of round cells.
  for (genvar g = 0; g < Cells; g++) begin : g_cell
    aes_round_cell #(
      .Rcon      (RCON[g]),
      .LastRound (g == Cells - 1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i ((g == 0) ? valid0_q : cell_valid[(g == 0) ? 0 : g - 1]),
      .state_i ((g == 0) ? state0_q : cell_state[(g == 0) ? 0 : g - 1]),
      .key_i   ((g == 0) ? key0_q   : cell_key[(g == 0) ? 0 : g - 1]),
      .valid_o (cell_valid[g]),
      .state_o (cell_state[g]),
      .key_o   (cell_key[g])
    );
  end

  // The last cell's register is the output register.
  assign out_if.valid     = cell_valid[Cells - 1];
  assign out_if.data_high = cell_state[Cells - 1][127:64];
  assign out_if.data_low  = cell_state[Cells - 1][63:0];

endmodule

[sv/aes_round_cell.sv]
// One round cell: state and round key registers, advanced one round per cycle while en_i is high.
module aes_round_cell #(
  parameter logic [7:0] Rcon      = 8'h01,
  parameter bit         LastRound = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  aes_pkg::block_t   state_i,
  input  aes_pkg::block_t   key_i,
  output logic              valid_o,
  output aes_pkg::block_t   state_o,
  output aes_pkg::block_t   key_o
);

  logic            valid_q;
  aes_pkg::block_t state_q, state_d;
  aes_pkg::block_t key_q, key_d;

  // Round key expansion and round transform.
  always_comb begin
    key_d   = aes_pkg::next_key(key_i, Rcon);
    state_d = aes_pkg::round_fn(state_i, key_d, !LastRound);
  end

  // Control flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload moves with the stage enable.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      key_q   <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;

endmodule

[verif/tb_aes128_block_encrypt_top.sv]
// Testbench for the AES-128 block encryption top level: keyed runs against a built-in cipher model.
`timescale 1ns / 100ps

module tb_aes128_block_encrypt_top;

  localparam int unsigned PipeDepth  = 11;
  localparam longint      CycleLimit = 400000;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block128_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  aes_stream_if plain_if ();
  aes_stream_if cipher_if ();

  aes128_block_encrypt_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (plain_if.sink),
    .out_if  (cipher_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Model state: the current cipher key and the queue of awaited ciphertexts.
  logic [63:0] model_key_hi;
  logic [63:0] model_key_lo;
  block128_t   cipher_expected_q[$];
  int          error_count;
  longint      cycle_count;
  bit          sink_hold;
  int unsigned sink_hold_cycles;

  // Clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("aes128_block_encrypt_top test failed");
      $finish;
    end
  end

  // Multiply two field elements in GF(2^8).
  function automatic logic [7:0] gf_product(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // S-box computed from the field inverse and the affine transform.
  function automatic logic [7:0] subst_byte(logic [7:0] x);
    logic [7:0] inv;
    logic [7:0] base;
    inv = 8'h01;
    base = x;
    for (int e = 0; e < 8; e++) begin
      if (8'd254 >> e & 1) inv = gf_product(inv, base);
      base = gf_product(base, base);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
         ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  // Full AES-128 encryption of one block under the model key.
  function automatic block128_t encrypt_block(block128_t pt);
    logic [7:0]   st[16];
    logic [7:0]   tmp[16];
    logic [7:0]   rk[16];
    logic [7:0]   kt[4];
    logic [127:0] flat;
    logic [127:0] kflat;
    logic [7:0]   rcon;
    logic [7:0]   a0, a1, a2, a3;
    flat = pt;
    kflat = {model_key_hi, model_key_lo};
    rcon = 8'h01;
    for (int i = 0; i < 16; i++) begin
      st[i] = flat[127 - 8 * i -: 8] ^ kflat[127 - 8 * i -: 8];
      rk[i] = kflat[127 - 8 * i -: 8];
    end
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          tmp[r + 4 * c] = subst_byte(st[r + 4 * ((c + r) % 4)]);
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = tmp[4 * c]; a1 = tmp[4 * c + 1]; a2 = tmp[4 * c + 2]; a3 = tmp[4 * c + 3];
          tmp[4 * c]     = gf_product(a0, 2) ^ gf_product(a1, 3) ^ a2 ^ a3;
          tmp[4 * c + 1] = a0 ^ gf_product(a1, 2) ^ gf_product(a2, 3) ^ a3;
          tmp[4 * c + 2] = a0 ^ a1 ^ gf_product(a2, 2) ^ gf_product(a3, 3);
          tmp[4 * c + 3] = gf_product(a0, 3) ^ a1 ^ a2 ^ gf_product(a3, 2);
        end
      end
      // Key schedule step: RotWord, SubWord and round constant.
      kt[0] = subst_byte(rk[13]) ^ rcon;
      kt[1] = subst_byte(rk[14]);
      kt[2] = subst_byte(rk[15]);
      kt[3] = subst_byte(rk[12]);
      for (int i = 0; i < 4; i++) rk[i] ^= kt[i];
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i - 4];
      rcon = gf_product(rcon, 2);
      for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) flat[127 - 8 * i -: 8] = st[i];
    return flat;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // Register write over the configuration port, setup then access cycle.
  task automatic write_key_reg(aes_pkg::reg_idx_e idx, logic [63:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(8 * idx);
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == aes_pkg::RegKeyHigh) model_key_hi = value;
    else model_key_lo = value;
  endtask

  task automatic load_key(logic [63:0] hi, logic [63:0] lo);
    write_key_reg(aes_pkg::RegKeyHigh, hi);
    write_key_reg(aes_pkg::RegKeyLow, lo);
  endtask

  // Offer one plaintext block after an optional gap, wait until it is taken.
  // The source stays valid afterwards; idle_source withdraws it.
  task automatic send_block(block128_t pt, int unsigned gap);
    if (gap != 0) begin
      plain_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    plain_if.valid <= 1'b1;
    plain_if.data_high <= pt.hi;
    plain_if.data_low <= pt.lo;
    @(posedge clk_i);
    while (!plain_if.ready) @(posedge clk_i);
    cipher_expected_q.push_back(encrypt_block(pt));
    @(negedge clk_i);
  endtask

  // Stop offering plaintext.
  task automatic idle_source();
    plain_if.valid <= 1'b0;
  endtask

  // Wait for every awaited ciphertext, then let the chain settle.
  task automatic drain_pipeline();
    idle_source();
    while (cipher_expected_q.size() != 0) @(negedge clk_i);
    repeat (PipeDepth + 4) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Sink back-pressure: random stalls, or a long hold when requested.
  initial begin
    cipher_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold) begin
        cipher_if.ready <= 1'b0;
        sink_hold_cycles++;
      end else if (cipher_if.ready && $urandom_range(0, 3) == 0) begin
        cipher_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        cipher_if.ready <= 1'b1;
      end else begin
        cipher_if.ready <= 1'b1;
      end
    end
  end

  // Compare each ciphertext transaction with the oldest awaited one.
  always @(posedge clk_i) begin
    block128_t want;
    if (rst_ni && cipher_if.valid && cipher_if.ready) begin
      if (cipher_expected_q.size() == 0) begin
        report_mismatch("unexpected block", cipher_if.data_high, '0);
      end else begin
        want = cipher_expected_q.pop_front();
        if (cipher_if.data_high !== want.hi)
          report_mismatch("cipher_high", cipher_if.data_high, want.hi);
        if (cipher_if.data_low !== want.lo)
          report_mismatch("cipher_low", cipher_if.data_low, want.lo);
      end
    end
  end

  // Known-answer vectors, extreme blocks and extreme keys.
  task automatic test_directed();
    send_block({64'h3243f6a8885a308d, 64'h313198a2e0370734}, 0);
    drain_pipeline();
    load_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_block({64'h3243f6a8885a308d, 64'h313198a2e0370734}, 0);
    send_block({64'h0011223344556677, 64'h8899aabbccddeeff}, 1);
    drain_pipeline();
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block({64'h0011223344556677, 64'h8899aabbccddeeff}, 0);
    send_block('0, 0);
    send_block('1, 0);
    drain_pipeline();
    load_key('1, '1);
    send_block('0, 0);
    send_block('1, 0);
    send_block({64'h8000000000000000, 64'h0000000000000001}, 0);
    send_block({64'haaaaaaaaaaaaaaaa, 64'h5555555555555555}, 2);
    drain_pipeline();
  endtask

  // Random blocks under several random keys with random gaps on both sides.
  task automatic test_random_keys();
    for (int k = 0; k < 6; k++) begin
      load_key(rand64(), rand64());
      for (int n = 0; n < 80; n++)
        send_block({rand64(), rand64()}, ($urandom_range(0, 2) == 0) ?
                   $urandom_range(0, 12) : 0);
      drain_pipeline();
    end
  endtask

  // Long sink hold while the source keeps offering, then a full pause.
  task automatic test_backpressure();
    load_key(rand64(), rand64());
    sink_hold_cycles = 0;
    sink_hold = 1'b1;
    fork
      begin
        while (sink_hold_cycles < 60) @(negedge clk_i);
        sink_hold = 1'b0;
      end
      for (int n = 0; n < 30; n++) send_block({rand64(), rand64()}, 0);
    join
    idle_source();
    while (cipher_expected_q.size() != 0) @(negedge clk_i);
    for (int n = 0; n < 20; n++) send_block({rand64(), rand64()}, 0);
    drain_pipeline();
  endtask

  // Main sequence.
  initial begin
    error_count = 0;
    cycle_count = 0;
    sink_hold = 1'b0;
    sink_hold_cycles = 0;
    model_key_hi = '0;
    model_key_lo = '0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    plain_if.valid = 1'b0;
    plain_if.data_high = '0;
    plain_if.data_low = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_keys();
    test_backpressure();
    if (error_count == 0) begin
      $display("aes128_block_encrypt_top test passed");
    end else begin
      $display("aes128_block_encrypt_top test failed");
    end
    $finish;
  end

endmodule
